### sv/blr_pkg.sv
package blr_pkg;

   localparam int COORD_WIDTH = 12;

   localparam int DEC_WIDTH  = COORD_WIDTH + 3;
   localparam int STR_WIDTH  = COORD_WIDTH + 1;
   localparam int DIAG_WIDTH = COORD_WIDTH + 2;

   localparam int REQ_DATA_WIDTH = ((4 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;

   typedef enum logic [0:0] {
      FUNC_START = 1'b0,
      FUNC_STEP  = 1'b1
   } func_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] cur_x;
      logic signed [COORD_WIDTH-1:0] cur_y;
      logic signed [DEC_WIDTH-1:0]   decision;
      logic [STR_WIDTH-1:0]          incr_straight;
      logic signed [DIAG_WIDTH-1:0]  incr_diag;
      logic [COORD_WIDTH-1:0]        remaining;
      logic                          major_is_y;
      logic                          step_x_neg;
      logic                          step_y_neg;
   } line_state_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pixel_x;
      logic signed [COORD_WIDTH-1:0] pixel_y;
      logic                          pixel_valid;
      logic                          last_pixel;
   } pixel_type;

endpackage

### sv/blr_setup.sv
module blr_setup (
   input  logic signed [blr_pkg::COORD_WIDTH-1:0] x_start,
   input  logic signed [blr_pkg::COORD_WIDTH-1:0] y_start,
   input  logic signed [blr_pkg::COORD_WIDTH-1:0] x_end,
   input  logic signed [blr_pkg::COORD_WIDTH-1:0] y_end,
   output blr_pkg::line_state_type                setup_state
);

   localparam int CW = blr_pkg::COORD_WIDTH;

   logic signed [CW:0] x_diff;
   logic signed [CW:0] y_diff;
   logic signed [CW:0] x_diff_neg;
   logic signed [CW:0] y_diff_neg;
   logic [CW-1:0]      dx;
   logic [CW-1:0]      dy;
   logic [CW-1:0]      dmaj;
   logic [CW-1:0]      dmin;
   logic               x_neg;
   logic               y_neg;
   logic               major_y;

   always_comb begin
      x_diff     = {x_end[CW-1], x_end} - {x_start[CW-1], x_start};
      y_diff     = {y_end[CW-1], y_end} - {y_start[CW-1], y_start};
      x_diff_neg = (CW+1)'(0) - x_diff;
      y_diff_neg = (CW+1)'(0) - y_diff;
      x_neg      = x_diff[CW];
      y_neg      = y_diff[CW];
      dx         = x_neg ? x_diff_neg[CW-1:0] : x_diff[CW-1:0];
      dy         = y_neg ? y_diff_neg[CW-1:0] : y_diff[CW-1:0];
      major_y    = dy > dx;
      dmaj       = major_y ? dy : dx;
      dmin       = major_y ? dx : dy;

      setup_state.cur_x         = x_start;
      setup_state.cur_y         = y_start;
      setup_state.decision      = $signed({2'b00, dmin, 1'b0} - {3'b000, dmaj});
      setup_state.incr_straight = {dmin, 1'b0};
      setup_state.incr_diag     = $signed({1'b0, dmin, 1'b0} - {1'b0, dmaj, 1'b0});
      setup_state.remaining     = dmaj;
      setup_state.major_is_y    = major_y;
      setup_state.step_x_neg    = x_neg;
      setup_state.step_y_neg    = y_neg;
   end

endmodule

### sv/blr_step.sv
module blr_step (
   input  blr_pkg::line_state_type state,
   output blr_pkg::line_state_type next_state,
   output blr_pkg::pixel_type      pixel
);

   localparam int CW  = blr_pkg::COORD_WIDTH;
   localparam int DW  = blr_pkg::DEC_WIDTH;
   localparam int SW  = blr_pkg::STR_WIDTH;

   logic                 active;
   logic                 diag;
   logic signed [DW-1:0] incr;
   logic [CW-1:0]        sx;
   logic [CW-1:0]        sy;
   logic [CW-1:0]        x_moved;
   logic [CW-1:0]        y_moved;
   logic [CW-1:0]        remaining_dec;

   always_comb begin
      active        = state.remaining != '0;
      diag          = state.decision > 0;
      incr          = diag ? DW'(state.incr_diag)
                           : $signed({{(DW-SW){1'b0}}, state.incr_straight});
      sx            = state.step_x_neg ? '1 : CW'(1);
      sy            = state.step_y_neg ? '1 : CW'(1);
      x_moved       = state.cur_x + sx;
      y_moved       = state.cur_y + sy;
      remaining_dec = state.remaining - CW'(1);

      next_state = state;
      pixel      = '0;
      if (active) begin
         pixel.pixel_x       = state.cur_x;
         pixel.pixel_y       = state.cur_y;
         pixel.pixel_valid   = 1'b1;
         pixel.last_pixel    = remaining_dec == '0;
         next_state.remaining = remaining_dec;
         next_state.decision  = state.decision + incr;
         if (state.major_is_y) begin
            next_state.cur_y = $signed(y_moved);
            if (diag) begin
               next_state.cur_x = $signed(x_moved);
            end
         end else begin
            next_state.cur_x = $signed(x_moved);
            if (diag) begin
               next_state.cur_y = $signed(y_moved);
            end
         end
      end
   end

endmodule

### sv/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer for all eight octants. A start transaction (tuser 0) carries both
// endpoints and answers with one empty result (tuser 0); every following step transaction
// (tuser 1) returns the next pixel of the line, start point included and end point excluded,
// with tlast on the final pixel. Steps with no line active, and any step on a zero-length
// line, return tuser 0 with zero data. A new start drops the line in progress. Every
// transaction produces exactly one result, presented in the cycle after acceptance; the block
// takes one transaction per clock, limited only by the single add and compare of the decision
// update, and keeps accepting while the output register is empty or drained in the same cycle.
module bresenham_line_rasterizer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // x_start, y_start, x_end, y_end
   input  logic [blr_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // func
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_x, pixel_y
   output logic [blr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // pixel_valid
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int CW = blr_pkg::COORD_WIDTH;

   blr_pkg::line_state_type state_ff;
   blr_pkg::line_state_type state_in;
   blr_pkg::line_state_type setup_state;
   blr_pkg::line_state_type step_state;
   blr_pkg::pixel_type      step_pixel;
   blr_pkg::pixel_type      pixel_ff;
   blr_pkg::pixel_type      pixel_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    accept;

   blr_setup u_setup (
      .x_start     ($signed(req_tdata[CW-1:0])),
      .y_start     ($signed(req_tdata[2*CW-1:CW])),
      .x_end       ($signed(req_tdata[3*CW-1:2*CW])),
      .y_end       ($signed(req_tdata[4*CW-1:3*CW])),
      .setup_state (setup_state)
   );

   blr_step u_step (
      .state      (state_ff),
      .next_state (step_state),
      .pixel      (step_pixel)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      pixel_in     = pixel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (blr_pkg::func_type'(req_tuser) == blr_pkg::FUNC_STEP) begin
            state_in = step_state;
            pixel_in = step_pixel;
         end else begin
            state_in = setup_state;
            pixel_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = blr_pkg::RSP_DATA_WIDTH'({pixel_ff.pixel_y, pixel_ff.pixel_x});
   assign rsp_tuser  = pixel_ff.pixel_valid;
   assign rsp_tlast  = pixel_ff.last_pixel;

endmodule

### tb/tb_bresenham_line_rasterizer_core.sv
`timescale 1ns / 100ps

module tb_bresenham_line_rasterizer_core;

   localparam int CW          = blr_pkg::COORD_WIDTH;
   localparam int DW          = blr_pkg::DEC_WIDTH;
   localparam int SW          = blr_pkg::STR_WIDTH;
   localparam int GW          = blr_pkg::DIAG_WIDTH;
   localparam int RQW         = blr_pkg::REQ_DATA_WIDTH;
   localparam int RSW         = blr_pkg::RSP_DATA_WIDTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 275;

   typedef struct {
      blr_pkg::func_type  func;
      int                 xs;
      int                 ys;
      int                 xe;
      int                 ye;
      bit                 typed;
      blr_pkg::pixel_type want;
   } line_row_type;

   logic           clock      = 1'b0;
   logic           reset      = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [RQW-1:0] req_tdata  = '0;
   logic           req_tuser  = 1'b0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [RSW-1:0] rsp_tdata;
   logic           rsp_tuser;
   logic           rsp_tlast;

   blr_pkg::line_state_type line_track = '0;
   blr_pkg::pixel_type      pending_pixels[$];
   blr_pkg::pixel_type      oldest_pixel;
   line_row_type            directed_rows[$];

   int  snd_idle_pct  = 0;
   int  rcv_stall_pct = 0;
   bit  hold_go       = 1'b0;
   bit  hold_active   = 1'b0;
   int  errors        = 0;
   int  cycle_count   = 0;

   bresenham_line_rasterizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL bresenham_line_rasterizer_core");
         $finish;
      end
   end

   // x_start, y_start, x_end, y_end from the lowest bit up
   function automatic logic [RQW-1:0] pack_ends(input int xs, input int ys,
                                                input int xe, input int ye);
      logic [RQW-1:0] d;
      d = '0;
      d[0*CW +: CW] = xs[CW-1:0];
      d[1*CW +: CW] = ys[CW-1:0];
      d[2*CW +: CW] = xe[CW-1:0];
      d[3*CW +: CW] = ye[CW-1:0];
      return d;
   endfunction

   function automatic logic [RQW-1:0] rand_data();
      return RQW'({$urandom, $urandom});
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v > 2047) return 2047;
      if (v < -2048) return -2048;
      return v;
   endfunction

   function automatic int abs_int(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // advances the tracked line by one transaction and returns the pixel it yields
   function automatic blr_pkg::pixel_type trace_pixel(input blr_pkg::func_type f,
                                                      input logic [RQW-1:0] d);
      int                 xa, ya, xb, yb, dx, dy, dmaj, dmin, dec;
      logic               diag;
      blr_pkg::pixel_type px;
      px = '0;
      if (f == blr_pkg::FUNC_START) begin
         xa = $signed(d[0*CW +: CW]);
         ya = $signed(d[1*CW +: CW]);
         xb = $signed(d[2*CW +: CW]);
         yb = $signed(d[3*CW +: CW]);
         line_track.step_x_neg = xa > xb;
         line_track.step_y_neg = ya > yb;
         dx = line_track.step_x_neg ? xa - xb : xb - xa;
         dy = line_track.step_y_neg ? ya - yb : yb - ya;
         line_track.major_is_y = dy > dx;
         dmaj = line_track.major_is_y ? dy : dx;
         dmin = line_track.major_is_y ? dx : dy;
         line_track.decision      = DW'(2 * dmin - dmaj);
         line_track.incr_straight = SW'(2 * dmin);
         line_track.incr_diag     = GW'(2 * (dmin - dmaj));
         line_track.cur_x         = CW'(xa);
         line_track.cur_y         = CW'(ya);
         line_track.remaining     = CW'(dmaj);
      end else if (line_track.remaining != 0) begin
         px.pixel_x     = line_track.cur_x;
         px.pixel_y     = line_track.cur_y;
         px.pixel_valid = 1'b1;
         line_track.remaining = line_track.remaining - 1'b1;
         px.last_pixel  = (line_track.remaining == 0);
         dec  = line_track.decision;
         diag = dec > 0;
         if (diag) dec = dec + int'(line_track.incr_diag);
         else dec = dec + int'({1'b0, line_track.incr_straight});
         line_track.decision = DW'(dec);
         if (line_track.major_is_y || diag) begin
            line_track.cur_y = CW'(int'(line_track.cur_y) + (line_track.step_y_neg ? -1 : 1));
         end
         if (!line_track.major_is_y || diag) begin
            line_track.cur_x = CW'(int'(line_track.cur_x) + (line_track.step_x_neg ? -1 : 1));
         end
      end
      return px;
   endfunction

   task automatic offer(input blr_pkg::func_type f, input logic [RQW-1:0] d,
                        input bit typed, input blr_pkg::pixel_type want);
      blr_pkg::pixel_type px;
      while (int'($urandom_range(99)) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= rand_data();
         req_tuser  <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      px = trace_pixel(f, d);
      pending_pixels.push_back(typed ? want : px);
      @(negedge clock);
   endtask

   task automatic add_row(input blr_pkg::func_type f, input int xs, input int ys,
                          input int xe, input int ye, input bit typed, input int wx,
                          input int wy, input bit wv, input bit wl);
      line_row_type r;
      r.func  = f;
      r.xs    = xs;
      r.ys    = ys;
      r.xe    = xe;
      r.ye    = ye;
      r.typed = typed;
      r.want.pixel_x     = wx[CW-1:0];
      r.want.pixel_y     = wy[CW-1:0];
      r.want.pixel_valid = wv;
      r.want.last_pixel  = wl;
      directed_rows.push_back(r);
   endtask

   task automatic step_noise();
      offer(blr_pkg::FUNC_STEP, rand_data(), 1'b0, '0);
   endtask

   task automatic run_phase(input int n_items);
      int sent, xs, ys, xe, ye, dmaj, n_steps, shape;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 85) begin
            xs = rand_coord();
            ys = rand_coord();
            if ($urandom_range(9) == 0) begin
               xe = rand_coord();
               ye = rand_coord();
            end else begin
               xe = clamp_coord(xs + int'($urandom_range(48)) - 24);
               ye = clamp_coord(ys + int'($urandom_range(48)) - 24);
            end
            shape = $urandom_range(19);
            case (shape)
               0: begin
                  xe = xs;
                  ye = ys;
               end
               1: ye = ys;
               2: xe = xs;
               3: ye = clamp_coord(ys + (xe - xs));
               default: ;
            endcase
            offer(blr_pkg::FUNC_START, pack_ends(xs, ys, xe, ye), 1'b0, '0);
            dmaj = (abs_int(xe - xs) > abs_int(ye - ys)) ? abs_int(xe - xs) : abs_int(ye - ys);
            n_steps = (dmaj > 40) ? int'($urandom_range(40)) : dmaj + int'($urandom_range(2));
            if ($urandom_range(9) == 0) n_steps = $urandom_range(n_steps);
            repeat (n_steps) step_noise();
            sent = sent + 1 + n_steps;
         end else begin
            offer(blr_pkg::func_type'(1'($urandom_range(1))), rand_data(), 1'b0, '0);
            sent = sent + 1;
         end
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= hold_active ? 1'b0 : (int'($urandom_range(99)) >= rcv_stall_pct);
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (hold_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t unexpected transaction: expected none, %s %0d y %0d valid %0b last %0b",
                     $time, "got x", $signed(rsp_tdata[0 +: CW]),
                     $signed(rsp_tdata[CW +: CW]), rsp_tuser, rsp_tlast);
         end else begin
            oldest_pixel = pending_pixels.pop_front();
            check_field("pixel_x", $signed(oldest_pixel.pixel_x), $signed(rsp_tdata[0 +: CW]));
            check_field("pixel_y", $signed(oldest_pixel.pixel_y), $signed(rsp_tdata[CW +: CW]));
            check_field("pixel_valid", int'(oldest_pixel.pixel_valid), int'(rsp_tuser));
            check_field("last_pixel", int'(oldest_pixel.last_pixel), int'(rsp_tlast));
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(blr_pkg::FUNC_STEP,   123,   -45,     7,     9, 1, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_START,    0,     0,     0,     0, 1, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_STEP,     0,     0,     0,     0, 1, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_START, -2048, -2048,  2047,  2047, 1, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_STEP,     0,     0,     0,     0, 1, -2048, -2048, 1, 0);
      add_row(blr_pkg::FUNC_STEP,    -1,    -1,    -1,    -1, 0, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_STEP,  2047,  2047,  2047,  2047, 0, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_START,  2047, -2048, -2048,  2047, 1, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_STEP, -2048, -2048, -2048, -2048, 1, 2047, -2048, 1, 0);
      add_row(blr_pkg::FUNC_STEP,     0,     0,     0,     0, 0, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_START,    5,     3,     6,     3, 1, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_STEP,     0,     0,     0,     0, 1, 5, 3, 1, 1);
      add_row(blr_pkg::FUNC_STEP,     0,     0,     0,     0, 1, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_START,    0,     0,    -3,    -5, 1, 0, 0, 0, 0);
      repeat (6) add_row(blr_pkg::FUNC_STEP, 1, 2, 3, 4, 0, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_START,  2047,  2047,  2047,  2043, 1, 0, 0, 0, 0);
      repeat (4) add_row(blr_pkg::FUNC_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(blr_pkg::FUNC_STEP,     0,     0,     0,     0, 1, 0, 0, 0, 0);

      foreach (directed_rows[i]) begin
         offer(directed_rows[i].func,
               pack_ends(directed_rows[i].xs, directed_rows[i].ys,
                         directed_rows[i].xe, directed_rows[i].ye),
               directed_rows[i].typed, directed_rows[i].want);
      end

      hold_go = 1'b1;
      run_phase(PHASE_ITEMS);
      snd_idle_pct  = 81;
      rcv_stall_pct = 0;
      run_phase(PHASE_ITEMS);
      snd_idle_pct  = 0;
      rcv_stall_pct = 81;
      run_phase(PHASE_ITEMS);
      snd_idle_pct  = 22;
      rcv_stall_pct = 22;
      run_phase(PHASE_ITEMS);

      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("PASS bresenham_line_rasterizer_core");
      end else begin
         $display("FAIL bresenham_line_rasterizer_core");
      end
      $finish;
   end

endmodule
